@@ hdl/apfm_pkg.sv @@
// Shared widths, register indexes and types for the affine pixel forward map.
// No dependencies; every other file in hdl/ uses this package.

package apfm_pkg;

	// Field widths of the pixel streams and registers
	localparam int COORD_W    = 12;
	localparam int COLOR_W    = 8;
	localparam int COEF_W     = 24;
	localparam int OFFS_W     = 32;
	localparam int DIM_W      = 13;
	localparam int FRAC_BITS  = 16;
	localparam int MAX_DIM    = 4096;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Signed coef times zero-extended coordinate, then sum of two products and an offset
	localparam int PROD_W  = COEF_W + COORD_W + 1;
	localparam int SUM_W   = PROD_W + 3;
	localparam int TRUNC_W = SUM_W - 1 - FRAC_BITS;

	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;
	localparam logic [DIM_W-1:0]  DIM_MAX  = DIM_W'(MAX_DIM);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_XX  = 3'd0,
		REG_COEF_XY  = 3'd1,
		REG_COEF_YX  = 3'd2,
		REG_COEF_YY  = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5,
		REG_CANVAS_W = 3'd6,
		REG_CANVAS_H = 3'd7
	} cfg_reg_t;

	// Current transform and clamped canvas bounds, as seen by the datapath
	typedef struct packed {
		logic signed [COEF_W-1:0] coef_xx;
		logic signed [COEF_W-1:0] coef_xy;
		logic signed [COEF_W-1:0] coef_yx;
		logic signed [COEF_W-1:0] coef_yy;
		logic signed [OFFS_W-1:0] offset_x;
		logic signed [OFFS_W-1:0] offset_y;
		logic [DIM_W-1:0]         width_lim;
		logic [DIM_W-1:0]         height_lim;
	} xform_cfg_t;

endpackage

@@ hdl/apfm_if.sv @@
// Valid/ready stream interfaces for source pixels and mapped pixels.
// Depends on apfm_pkg for field widths.

interface apfm_src_if;
	logic                          valid;
	logic                          ready;
	logic [apfm_pkg::COORD_W-1:0]  src_x;
	logic [apfm_pkg::COORD_W-1:0]  src_y;
	logic [apfm_pkg::COLOR_W-1:0]  red_in;
	logic [apfm_pkg::COLOR_W-1:0]  green_in;
	logic [apfm_pkg::COLOR_W-1:0]  blue_in;

	modport source (output valid, src_x, src_y, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, src_x, src_y, red_in, green_in, blue_in, output ready);
endinterface

interface apfm_dst_if;
	logic                          valid;
	logic                          ready;
	logic [apfm_pkg::COORD_W-1:0]  dst_x;
	logic [apfm_pkg::COORD_W-1:0]  dst_y;
	logic [apfm_pkg::COLOR_W-1:0]  red_out;
	logic [apfm_pkg::COLOR_W-1:0]  green_out;
	logic [apfm_pkg::COLOR_W-1:0]  blue_out;

	modport source (output valid, dst_x, dst_y, red_out, green_out, blue_out, input ready);
	modport sink   (input valid, dst_x, dst_y, red_out, green_out, blue_out, output ready);
endinterface

@@ hdl/affine_pixel_forward_map.sv @@
// Affine pixel forward map, top level.
// Depends on apfm_pkg, apfm_if.sv, apfm_cfg and apfm_pipe.
//
// Usage:
//  - src: source pixel requests (column, row, RGB), valid/ready.
//  - dst: mapped pixel requests (destination column, row, RGB), valid/ready.
//    A source pixel whose destination falls outside the canvas is dropped,
//    so dst carries zero or one request per src request, in order.
//  - cfg_we/cfg_index/cfg_data: write-only register port. Index 0..3 are
//    the signed Q7.16 weights xx, xy, yx, yy; 4 and 5 the Q15.16 offsets;
//    6 and 7 the canvas width and height. Write only while the block is idle.
//  - Path: a src request passes the three register stages before dst valid
//    rises for it, if it is kept; a stall on dst.ready can hold it on the way.
//  - Throughput: one pixel per clock while dst.ready is high, set by the
//    three-stage pipeline (multiply, sum, truncate and bound check).
//  - Reset (arst_n low): pipeline empties, weights return to identity,
//    offsets to zero, canvas bounds to 4096 by 4096.
//  - Stall: when dst.ready is low the output holds; empty stages upstream
//    still fill, and src.ready drops only once all three stages are full.
//    Nothing is lost or repeated.

module affine_pixel_forward_map (
	input  logic                               clk,
	input  logic                               arst_n,
	apfm_src_if.sink                           src,
	apfm_dst_if.source                         dst,
	input  logic                               cfg_we,
	input  logic [apfm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [apfm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Live transform, bounds already clamped to the largest canvas
	apfm_pkg::xform_cfg_t xform;

	apfm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.xform     (xform)
	);

	// Stage 1 products, stage 2 exact sums, stage 3 truncation and canvas test
	apfm_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.xform  (xform),
		.src    (src),
		.dst    (dst)
	);

endmodule

@@ hdl/apfm_cfg.sv @@
// Configuration register file: matrix weights, offsets and canvas bounds.
// Depends on apfm_pkg.

module apfm_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [apfm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [apfm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output apfm_pkg::xform_cfg_t               xform
);

	logic signed [apfm_pkg::COEF_W-1:0] coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q;
	logic signed [apfm_pkg::OFFS_W-1:0] offset_x_q, offset_y_q;
	logic [apfm_pkg::DIM_W-1:0]         canvas_w_q, canvas_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q  <= apfm_pkg::COEF_ONE;
			coef_xy_q  <= '0;
			coef_yx_q  <= '0;
			coef_yy_q  <= apfm_pkg::COEF_ONE;
			offset_x_q <= '0;
			offset_y_q <= '0;
			canvas_w_q <= apfm_pkg::DIM_MAX;
			canvas_h_q <= apfm_pkg::DIM_MAX;
		end else if (cfg_we) begin
			unique case (apfm_pkg::cfg_reg_t'(cfg_index))
				apfm_pkg::REG_COEF_XX:  coef_xx_q  <= cfg_data[apfm_pkg::COEF_W-1:0];
				apfm_pkg::REG_COEF_XY:  coef_xy_q  <= cfg_data[apfm_pkg::COEF_W-1:0];
				apfm_pkg::REG_COEF_YX:  coef_yx_q  <= cfg_data[apfm_pkg::COEF_W-1:0];
				apfm_pkg::REG_COEF_YY:  coef_yy_q  <= cfg_data[apfm_pkg::COEF_W-1:0];
				apfm_pkg::REG_OFFSET_X: offset_x_q <= cfg_data[apfm_pkg::OFFS_W-1:0];
				apfm_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data[apfm_pkg::OFFS_W-1:0];
				apfm_pkg::REG_CANVAS_W: canvas_w_q <= cfg_data[apfm_pkg::DIM_W-1:0];
				apfm_pkg::REG_CANVAS_H: canvas_h_q <= cfg_data[apfm_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Bounds above the largest canvas are clamped so a destination always fits its field
	always_comb begin
		xform.coef_xx    = coef_xx_q;
		xform.coef_xy    = coef_xy_q;
		xform.coef_yx    = coef_yx_q;
		xform.coef_yy    = coef_yy_q;
		xform.offset_x   = offset_x_q;
		xform.offset_y   = offset_y_q;
		xform.width_lim  = (canvas_w_q > apfm_pkg::DIM_MAX) ? apfm_pkg::DIM_MAX : canvas_w_q;
		xform.height_lim = (canvas_h_q > apfm_pkg::DIM_MAX) ? apfm_pkg::DIM_MAX : canvas_h_q;
	end

endmodule

@@ hdl/apfm_pipe.sv @@
// Three-stage mapping datapath: multiply, sum, truncate and bound check.
// Depends on apfm_pkg and the stream interfaces in apfm_if.sv.

module apfm_pipe (
	input  logic                  clk,
	input  logic                  arst_n,
	input  apfm_pkg::xform_cfg_t  xform,
	apfm_src_if.sink              src,
	apfm_dst_if.source            dst
);

	localparam int PW = apfm_pkg::PROD_W;
	localparam int SW = apfm_pkg::SUM_W;
	localparam int FB = apfm_pkg::FRAC_BITS;
	localparam int TW = apfm_pkg::TRUNC_W;
	localparam int CW = apfm_pkg::COORD_W;
	localparam int KW = apfm_pkg::COLOR_W;

	logic en_s1, en_s2, en_s3;
	logic valid_s1, valid_s2, valid_s3;

	// Stage 1: four products
	logic signed [PW-1:0] p_xx_s1, p_xy_s1, p_yx_s1, p_yy_s1;
	logic [KW-1:0]        red_s1, green_s1, blue_s1;
	logic signed [CW:0]   sx_ext, sy_ext;

	// Stage 2: exact sums
	logic signed [SW-1:0] sum_x_s2, sum_y_s2;
	logic [KW-1:0]        red_s2, green_s2, blue_s2;
	logic signed [SW-1:0] sum_x, sum_y;

	// Stage 3: truncated destination (output register)
	logic [CW-1:0]        dst_x_s3, dst_y_s3;
	logic [KW-1:0]        red_s3, green_s3, blue_s3;
	logic                 ok_x, ok_y, hit;
	logic [TW-1:0]        int_x, int_y;

	// A stage takes new data when it is empty or its content moves on
	assign en_s3     = !valid_s3 || dst.ready;
	assign en_s2     = !valid_s2 || en_s3;
	assign en_s1     = !valid_s1 || en_s2;
	assign src.ready = en_s1;

	assign sx_ext = {1'b0, src.src_x};
	assign sy_ext = {1'b0, src.src_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= src.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && src.valid) begin
			p_xx_s1  <= xform.coef_xx * sx_ext;
			p_xy_s1  <= xform.coef_xy * sy_ext;
			p_yx_s1  <= xform.coef_yx * sx_ext;
			p_yy_s1  <= xform.coef_yy * sy_ext;
			red_s1   <= src.red_in;
			green_s1 <= src.green_in;
			blue_s1  <= src.blue_in;
		end
	end

	always_comb begin
		sum_x = {{(SW-PW){p_xx_s1[PW-1]}}, p_xx_s1}
		      + {{(SW-PW){p_xy_s1[PW-1]}}, p_xy_s1}
		      + {{(SW-apfm_pkg::OFFS_W){xform.offset_x[apfm_pkg::OFFS_W-1]}}, xform.offset_x};
		sum_y = {{(SW-PW){p_yx_s1[PW-1]}}, p_yx_s1}
		      + {{(SW-PW){p_yy_s1[PW-1]}}, p_yy_s1}
		      + {{(SW-apfm_pkg::OFFS_W){xform.offset_y[apfm_pkg::OFFS_W-1]}}, xform.offset_y};
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			sum_x_s2 <= sum_x;
			sum_y_s2 <= sum_y;
			red_s2   <= red_s1;
			green_s2 <= green_s1;
			blue_s2  <= blue_s1;
		end
	end

	// Truncation toward zero: a sum in (-1, 0) gives 0, anything at or below -1 is off canvas
	always_comb begin
		int_x = sum_x_s2[SW-1] ? '0 : sum_x_s2[SW-2:FB];
		int_y = sum_y_s2[SW-1] ? '0 : sum_y_s2[SW-2:FB];
		ok_x  = (!sum_x_s2[SW-1] || ((&sum_x_s2[SW-1:FB]) && (|sum_x_s2[FB-1:0])))
		      && (int_x < TW'(xform.width_lim));
		ok_y  = (!sum_y_s2[SW-1] || ((&sum_y_s2[SW-1:FB]) && (|sum_y_s2[FB-1:0])))
		      && (int_y < TW'(xform.height_lim));
		hit   = ok_x && ok_y;
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			dst_x_s3 <= int_x[CW-1:0];
			dst_y_s3 <= int_y[CW-1:0];
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
		end
	end

	assign dst.valid     = valid_s3;
	assign dst.dst_x     = dst_x_s3;
	assign dst.dst_y     = dst_y_s3;
	assign dst.red_out   = red_s3;
	assign dst.green_out = green_s3;
	assign dst.blue_out  = blue_s3;

endmodule
